[rtl/fdiv_pkg.sv]
// fdiv_pkg: shared types, constants and helpers for the float32 divider.
// No dependencies.
package fdiv_pkg;

    localparam int QUOT_BITS = 26;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;
    localparam logic [7:0] EXP_ALL1 = 8'hFF;
    localparam logic [7:0] EXP_MAXFIN = 8'hFE;
    localparam logic [22:0] FRAC_ALL1 = 23'h7F_FFFF;
    localparam logic [23:0] MANT_ALL1 = 24'hFF_FFFF;
    localparam logic [23:0] HIDDEN_BIT = 24'h80_0000;
    localparam logic signed [10:0] EXP_BIAS = 11'sd127;

    typedef enum logic [2:0] {
        RM_RNE = 3'd0,
        RM_RTZ = 3'd1,
        RM_RDN = 3'd2,
        RM_RUP = 3'd3,
        RM_RMM = 3'd4
    } t_rmode;

    // Classified request handed from front to back.
    typedef struct packed {
        logic             special;   // result fixed, no division needed
        logic [31:0]      spec_val;
        logic             sign;
        logic [2:0]       rm;
        logic [23:0]      ma;        // normalized mantissas
        logic [23:0]      mb;
        logic signed [10:0] exp;     // xa - xb + bias
    } t_req;

    // Per-stage state in the divide pipeline.
    typedef struct packed {
        logic             vld;
        logic             special;
        logic [31:0]      spec_val;
        logic             sign;
        logic [2:0]       rm;
        logic [24:0]      rem;
        logic [23:0]      mb;
        logic [25:0]      q;
        logic signed [10:0] exp;
    } t_stage;

    // Leading zero count of a 24-bit mantissa (0..23 for nonzero).
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int k = 23; k >= 0; k--) begin
            if (!found && v[k]) begin
                found = 1'b1;
                n = 5'(23 - k);
            end
        end
        return n;
    endfunction

endpackage

[rtl/fdiv_front.sv]
// fdiv_front: classifies operands, answers special cases, normalizes mantissas.
// Depends on fdiv_pkg.
module fdiv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [31:0]        i_dividend,
    input  logic [31:0]        i_divisor,
    input  logic [2:0]         i_rounding_mode,
    output logic               o_vld,
    output fdiv_pkg::t_req     o_req
);
    import fdiv_pkg::*;

    logic        sa, sb, sign;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma0, mb0;
    logic [4:0]  la, lb;
    t_req        n_req, r_req;
    logic        r_vld;

    always_comb begin
        sa = i_dividend[31];
        sb = i_divisor[31];
        ea = i_dividend[30:23];
        eb = i_divisor[30:23];
        fa = i_dividend[22:0];
        fb = i_divisor[22:0];
        sign = sa ^ sb;
        a_nan = (ea == EXP_ALL1) && (fa != '0);
        b_nan = (eb == EXP_ALL1) && (fb != '0);
        a_inf = (ea == EXP_ALL1) && (fa == '0);
        b_inf = (eb == EXP_ALL1) && (fb == '0);
        a_zero = (ea == '0) && (fa == '0);
        b_zero = (eb == '0) && (fb == '0);
        ma0 = {(ea != '0), fa};
        mb0 = {(eb != '0), fb};
        la = lzc24(ma0);
        lb = lzc24(mb0);

        n_req = '0;
        n_req.sign = sign;
        n_req.rm = i_rounding_mode;
        n_req.ma = ma0 << la;
        n_req.mb = mb0 << lb;
        n_req.exp = $signed({3'b000, (ea != '0) ? ea : 8'd1}) - $signed({6'd0, la})
                  - $signed({3'b000, (eb != '0) ? eb : 8'd1}) + $signed({6'd0, lb})
                  + EXP_BIAS;
        n_req.special = 1'b1;
        if (a_nan)
            n_req.spec_val = i_dividend | 32'h0040_0000;
        else if (b_nan)
            n_req.spec_val = i_divisor | 32'h0040_0000;
        else if ((a_zero && b_zero) || (a_inf && b_inf))
            n_req.spec_val = QNAN_DEFAULT;
        else if (a_zero || b_inf)
            n_req.spec_val = {sign, 31'd0};
        else if (b_zero || a_inf)
            n_req.spec_val = INF_BITS | {sign, 31'd0};
        else begin
            n_req.special = 1'b0;
            n_req.spec_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= 1'b0;
        else
            r_vld <= i_vld;
        r_req <= n_req;
    end

    assign o_vld = r_vld;
    assign o_req = r_req;

endmodule

[rtl/fdiv_queue.sv]
// fdiv_queue: short FIFO between front and back halves of the divider.
// Depends on fdiv_pkg.
module fdiv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fdiv_pkg::t_req     i_data,
    input  logic               i_pop,
    output logic               o_empty,
    output logic               o_full,
    output fdiv_pkg::t_req     o_data
);
    import fdiv_pkg::*;

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full = (r_cnt == (QPTR_W+1)'(QDEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

[rtl/fdiv_back.sv]
// fdiv_back: pipelined restoring mantissa divide, one quotient bit per stage,
// then normalize, denormalize, round and pack. Depends on fdiv_pkg.
module fdiv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  fdiv_pkg::t_req     i_req,
    output logic               o_vld,
    output logic [31:0]        o_quotient
);
    import fdiv_pkg::*;

    // r_st[k] holds state after k quotient bits.
    t_stage r_st [QUOT_BITS+1];
    t_stage n_st [QUOT_BITS+1];

    always_comb begin
        n_st[0] = '0;
        n_st[0].vld = i_vld;
        n_st[0].special = i_req.special;
        n_st[0].spec_val = i_req.spec_val;
        n_st[0].sign = i_req.sign;
        n_st[0].rm = i_req.rm;
        n_st[0].rem = {1'b0, i_req.ma};
        n_st[0].mb = i_req.mb;
        n_st[0].exp = i_req.exp;
        for (int k = 1; k <= QUOT_BITS; k++) begin
            n_st[k] = r_st[k-1];
            if (r_st[k-1].rem >= {1'b0, r_st[k-1].mb}) begin
                n_st[k].rem = r_st[k-1].rem - {1'b0, r_st[k-1].mb};
                n_st[k].q = {r_st[k-1].q[24:0], 1'b1};
            end else begin
                n_st[k].q = {r_st[k-1].q[24:0], 1'b0};
            end
            if (k < QUOT_BITS) n_st[k].rem = {n_st[k].rem[23:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= QUOT_BITS; k++) begin
            if (!i_rst_n)
                r_st[k].vld <= 1'b0;
            else
                r_st[k].vld <= n_st[k].vld;
            r_st[k].special <= n_st[k].special;
            r_st[k].spec_val <= n_st[k].spec_val;
            r_st[k].sign <= n_st[k].sign;
            r_st[k].rm <= n_st[k].rm;
            r_st[k].rem <= n_st[k].rem;
            r_st[k].mb <= n_st[k].mb;
            r_st[k].q <= n_st[k].q;
            r_st[k].exp <= n_st[k].exp;
        end
    end

    // Stage A: normalize and denormalize.
    t_stage             sq;
    logic [26:0]        res;
    logic [23:0]        mant_a;
    logic [2:0]         grs_a;
    logic signed [10:0] e_a;
    logic [4:0]         sh;
    logic [26:0]        comb, lostmask;
    logic               r_a_vld, r_a_special, r_a_sign;
    logic [31:0]        r_a_spec;
    logic [2:0]         r_a_rm;
    logic [23:0]        r_a_mant;
    logic [2:0]         r_a_grs;
    logic signed [10:0] r_a_exp;

    always_comb begin
        sq = r_st[QUOT_BITS];
        res = {sq.q, (sq.rem != '0)};
        if (res[26]) begin
            mant_a = res[26:3];
            grs_a = res[2:0];
            e_a = sq.exp;
        end else begin
            mant_a = res[25:2];
            grs_a = {res[1], 1'b0, res[0]};
            e_a = sq.exp - 11'sd1;
        end
        sh = '0;
        comb = {mant_a, grs_a};
        lostmask = '0;
        if (e_a <= 11'sd0) begin
            sh = (e_a < -11'sd24) ? 5'd26 : 5'(11'sd1 - e_a);
            lostmask = (27'd1 << sh) - 27'd1;
            comb = {mant_a, grs_a} >> sh;
            comb[0] = comb[0] | (({mant_a, grs_a} & lostmask) != '0);
            e_a = 11'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_a_vld <= 1'b0;
        else
            r_a_vld <= sq.vld;
        r_a_special <= sq.special;
        r_a_spec <= sq.spec_val;
        r_a_sign <= sq.sign;
        r_a_rm <= sq.rm;
        r_a_mant <= comb[26:3];
        r_a_grs <= comb[2:0];
        r_a_exp <= e_a;
    end

    // Stage B: round and pack.
    logic               up, to_inf;
    logic [23:0]        mant_b;
    logic signed [10:0] e_b;
    logic [31:0]        n_q, r_q;
    logic               r_vld;

    always_comb begin
        case (r_a_rm)
            RM_RNE:  up = r_a_grs[2] && (r_a_mant[0] || (r_a_grs[1:0] != '0));
            RM_RDN:  up = r_a_sign && (r_a_grs != '0);
            RM_RUP:  up = !r_a_sign && (r_a_grs != '0);
            RM_RMM:  up = r_a_grs[2];
            default: up = 1'b0;
        endcase
        mant_b = r_a_mant;
        e_b = r_a_exp;
        if (up) begin
            if (r_a_mant == MANT_ALL1) begin
                mant_b = HIDDEN_BIT;
                e_b = r_a_exp + 11'sd1;
            end else begin
                mant_b = r_a_mant + 24'd1;
                if (r_a_exp == 11'sd0 && mant_b[23]) e_b = 11'sd1;
            end
        end
        case (r_a_rm)
            RM_RTZ:  to_inf = 1'b0;
            RM_RDN:  to_inf = r_a_sign;
            RM_RUP:  to_inf = !r_a_sign;
            default: to_inf = 1'b1;
        endcase
        if (r_a_special)
            n_q = r_a_spec;
        else if (e_b >= 11'sd255)
            n_q = to_inf ? (INF_BITS | {r_a_sign, 31'd0})
                         : {r_a_sign, EXP_MAXFIN, FRAC_ALL1};
        else
            n_q = {r_a_sign, e_b[7:0], mant_b[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= 1'b0;
        else
            r_vld <= r_a_vld;
        r_q <= n_q;
    end

    assign o_vld = r_vld;
    assign o_quotient = r_q;

    a_special_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && r_a_special |=> o_quotient == $past(r_a_spec))
        else $error("special result altered");
    a_denorm_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !r_a_special |-> r_a_exp >= 11'sd0)
        else $error("negative exponent after denormalize");
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |=> o_vld) else $error("result lost in pack stage");

endmodule

[rtl/float32_divider.sv]
// float32_divider: top level, IEEE-754 single-precision divider.
// Depends on fdiv_pkg, fdiv_front, fdiv_queue, fdiv_back.
//
// One divide request is accepted per cycle (start high while busy is low) and
// each gives exactly one quotient, shown for one cycle with o_done. A request
// passes through one classify stage, one queue slot, one input stage of
// the restoring divider, its 26 quotient-bit stages, one normalize/denormalize
// stage and one round/pack stage. The back pipeline never stalls, since
// results cannot be held off, so busy stays low and requests stream at full
// rate. Rounding modes: 0 nearest-even, 1 toward zero, 2 down, 3 up, 4
// nearest-away, 5-7 truncate with overflow to infinity. No exception flags
// are produced.
module float32_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  logic [2:0]  i_rounding_mode,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import fdiv_pkg::*;

    logic accept;
    logic f_vld;
    t_req f_req, q_req;
    logic q_empty, q_full, pop;

    assign accept = start && !busy;
    // Back end always drains, so the queue never fills in practice.
    assign busy = q_full;
    assign pop = !q_empty;

    fdiv_front u_front (
        .i_clk, .i_rst_n,
        .i_vld(accept),
        .i_dividend, .i_divisor, .i_rounding_mode,
        .o_vld(f_vld), .o_req(f_req)
    );

    fdiv_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(f_vld), .i_data(f_req),
        .i_pop(pop), .o_empty(q_empty), .o_full(q_full),
        .o_data(q_req)
    );

    fdiv_back u_back (
        .i_clk, .i_rst_n,
        .i_vld(pop), .i_req(q_req),
        .o_vld(o_done), .o_quotient
    );

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("divider stalled");
    a_front_to_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> f_vld) else $error("request dropped in front");
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_vld |=> !q_empty || pop) else $error("queue lost request");

endmodule

[sim/float32_divider_tb.sv]
// float32_divider_tb: self-checking testbench for the float32 divider.
// Depends on rtl/fdiv_pkg.sv and rtl/float32_divider.sv; a queue-fed driver and
// a strobe monitor check each quotient against a bit-exact divide predictor.
`timescale 1ns / 1ps

module float32_divider_tb;
    import fdiv_pkg::*;

    typedef struct {
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [2:0]  rmode;
    } t_div_req;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic [2:0]  rmode;
    logic        done;
    logic [31:0] quotient;

    t_div_req    pending_reqs[$];
    logic [31:0] expected_quots[$];
    int          idle_pct;      // sender idle chance, percent
    bit          hold_off;      // sender pauses until the pipe drains
    bit          failed = 1'b0;

    float32_divider i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_dividend     (dividend),
        .i_divisor      (divisor),
        .i_rounding_mode(rmode),
        .o_done         (done),
        .o_quotient     (quotient)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bit-exact quotient: specials, normalize, 26-bit restoring divide,
    // sticky, denormalize, round, overflow handling.
    function automatic logic [31:0] divide_f32(input logic [31:0] a, input logic [31:0] b,
                                               input logic [2:0] rm);
        logic        sa, sb, sgn, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic        up, any, to_inf;
        logic [7:0]  ea, eb;
        logic [22:0] fa, fb;
        logic [31:0] ma, mb, rem, q, res, mant, grs, comb, lost, outv;
        int          xa, xb, e, sh;
        sa = a[31]; sb = b[31]; sgn = sa ^ sb;
        ea = a[30:23]; eb = b[30:23];
        fa = a[22:0]; fb = b[22:0];
        a_nan = (ea == EXP_ALL1) && (fa != 0);
        b_nan = (eb == EXP_ALL1) && (fb != 0);
        a_inf = (ea == EXP_ALL1) && (fa == 0);
        b_inf = (eb == EXP_ALL1) && (fb == 0);
        a_zero = (ea == 0) && (fa == 0);
        b_zero = (eb == 0) && (fb == 0);
        if (a_nan || b_nan) return (a_nan ? a : b) | 32'h0040_0000;
        if (a_zero && b_zero) return QNAN_DEFAULT;
        if (a_zero) return {sgn, 31'd0};
        if (b_zero) return INF_BITS | {sgn, 31'd0};
        if (a_inf && b_inf) return QNAN_DEFAULT;
        if (a_inf) return INF_BITS | {sgn, 31'd0};
        if (b_inf) return {sgn, 31'd0};
        ma = {8'd0, (ea != 0), fa};
        mb = {8'd0, (eb != 0), fb};
        xa = (ea != 0) ? int'(ea) : 1;
        xb = (eb != 0) ? int'(eb) : 1;
        while (ma[23] == 1'b0) begin ma = ma << 1; xa--; end
        while (mb[23] == 1'b0) begin mb = mb << 1; xb--; end
        e = xa - xb + 127;
        rem = ma;
        q = 0;
        for (int i = QUOT_BITS; i > 0; i--) begin
            if (rem >= mb) begin
                rem = rem - mb;
                q = (q << 1) | 1;
            end else begin
                q = q << 1;
            end
            if (i > 1) rem = rem << 1;
        end
        res = (q << 1) | (rem != 0);
        if (res[26]) begin
            mant = (res >> 3) & 32'hFF_FFFF;
            grs = res & 7;
        end else begin
            mant = (res >> 2) & 32'hFF_FFFF;
            grs = {29'd0, res[1], 1'b0, res[0]};
            e = e - 1;
        end
        if (e <= 0) begin
            sh = 1 - e;
            if (sh > 26) sh = 26;
            comb = (mant << 3) | grs;
            lost = comb & ((32'd1 << sh) - 1);
            comb = comb >> sh;
            mant = (comb >> 3) & 32'hFF_FFFF;
            grs = (comb & 7) | (lost != 0);
            e = 0;
        end
        any = grs != 0;
        case (rm)
            RM_RNE: up = grs[2] && (mant[0] || grs[1:0] != 0);
            RM_RDN: up = sgn && any;
            RM_RUP: up = !sgn && any;
            RM_RMM: up = grs[2];
            default: up = 1'b0;
        endcase
        if (up) begin
            if (mant == 32'hFF_FFFF) begin
                mant = 32'h80_0000;
                e++;
            end else begin
                mant++;
                if (e == 0 && mant[23]) e = 1;
            end
        end
        outv = {sgn, 31'd0};
        if (e >= 255) begin
            case (rm)
                RM_RTZ: to_inf = 1'b0;
                RM_RDN: to_inf = sgn;
                RM_RUP: to_inf = !sgn;
                default: to_inf = 1'b1;
            endcase
            outv |= to_inf ? INF_BITS : {1'b0, EXP_MAXFIN, FRAC_ALL1};
        end else begin
            outv |= {1'b0, e[7:0], mant[22:0]};
        end
        return outv;
    endfunction

    // Operand mix: normals of nearby exponents as the largest share, plus specials,
    // subnormals and extreme exponents so overflow/underflow paths get hit.
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 15))
            0: v[30:23] = EXP_ALL1;                         // inf / NaN
            1: v[30:0] = {8'hFF, 23'd0};                    // inf
            2: v[30:23] = 8'd0;                             // subnormal
            3: v[30:0] = 31'd0;                             // zero
            4: v[30:23] = $urandom_range(0, 1) ? 8'hFE : 8'd1;
            5: v[30:0] = $urandom_range(0, 1) ? 31'd1 : {8'hFE, FRAC_ALL1};
            6: v[30:23] = 8'($urandom_range(0, 30));
            7: v[30:23] = 8'($urandom_range(220, 254));
            8: v[22:0] = $urandom_range(0, 1) ? 23'd0 : FRAC_ALL1;
            default: v[30:23] = 8'($urandom_range(100, 154));
        endcase
        return v;
    endfunction

    function automatic t_div_req make_req(input logic [31:0] a, input logic [31:0] b,
                                          input logic [2:0] rm);
        t_div_req r;
        r.dividend = a;
        r.divisor = b;
        r.rmode = rm;
        return r;
    endfunction

    // Driver: one request per accepted start; start stays up while requests
    // keep coming back to back.
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
            dividend <= '0;
            divisor <= '0;
            rmode <= '0;
        end else if (!start || !busy) begin
            if (pending_reqs.size() != 0 && !hold_off &&
                $urandom_range(0, 99) >= idle_pct) begin
                t_div_req r;
                r = pending_reqs.pop_front();
                start <= 1'b1;
                dividend <= r.dividend;
                divisor <= r.divisor;
                rmode <= r.rmode;
                expected_quots.push_back(divide_f32(r.dividend, r.divisor, r.rmode));
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed quotient is matched with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_quots.size() == 0) begin
                $display("%0t: unexpected quotient %h", $time, quotient);
                failed = 1'b1;
            end else begin
                logic [31:0] exp_q;
                exp_q = expected_quots.pop_front();
                if (quotient !== exp_q) begin
                    $display("%0t: quotient mismatch expected %h actual %h",
                             $time, exp_q, quotient);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [31:0] ops[$];
        hold_off = 1'b0;
        idle_pct = 25;
        rst_n = 1'b0;

        // Directed: each special case, extremes and every rounding mode.
        pending_reqs.push_back(make_req(32'h7FC0_0001, 32'h3F80_0000, RM_RNE)); // NaN a
        pending_reqs.push_back(make_req(32'h3F80_0000, 32'hFF80_0001, RM_RNE)); // sNaN b
        pending_reqs.push_back(make_req(32'h0000_0000, 32'h8000_0000, RM_RNE)); // 0/0
        pending_reqs.push_back(make_req(32'hFF80_0000, 32'h7F80_0000, RM_RTZ)); // inf/inf
        pending_reqs.push_back(make_req(32'hBF80_0000, 32'h0000_0000, RM_RDN)); // x/0
        pending_reqs.push_back(make_req(32'h8000_0000, 32'h4040_0000, RM_RUP)); // 0/x
        pending_reqs.push_back(make_req(32'h4040_0000, 32'hFF80_0000, RM_RMM)); // x/inf
        pending_reqs.push_back(make_req(32'h7F80_0000, 32'hC000_0000, 3'd5));   // inf/x
        pending_reqs.push_back(make_req(32'h0000_0001, 32'h7F7F_FFFF, RM_RUP)); // underflow
        pending_reqs.push_back(make_req(32'h0000_0001, 32'h3F80_0000, RM_RNE)); // subnormal
        pending_reqs.push_back(make_req(32'h007F_FFFF, 32'h0000_0003, RM_RNE));
        for (int m = 0; m < 8; m++) begin
            pending_reqs.push_back(make_req(32'h7F7F_FFFF, 32'h0000_0001, 3'(m)));
            pending_reqs.push_back(make_req(32'hBF80_0000, 32'h4040_0000, 3'(m)));
        end
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 25 : (phase == 1 ? 71 : 0);
            for (int n = 0; n < 380; n++)
                pending_reqs.push_back(make_req(rand_operand(), rand_operand(),
                                                3'($urandom_range(0, 7))));
            while (pending_reqs.size() > 190) @(posedge clk);
            // Let the pipeline drain completely before resuming.
            hold_off = 1'b1;
            while (start || expected_quots.size() != 0) @(posedge clk);
            hold_off = 1'b0;
            while (pending_reqs.size() != 0) @(posedge clk);
        end
        while (start) @(posedge clk);
        while (expected_quots.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (!failed) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
